// ----- rtl/tssup_pkg.sv -----
// shared types, constants and register indexes of the thermostat second tick supervisor
package tssup_pkg;

   // default limits, handed down from the top level parameters
   localparam int DAY_LAST_SECOND_DEF = 86399;
   localparam int DOWN_LIMIT_DEF      = 120;
   localparam int MINUTE_CAP_DEF      = 1440;
   localparam int HOLD_LIMIT_DEF      = 5;

   localparam int SEC_W  = 17;
   localparam int MIN_W  = 11;
   localparam int DOWN_W = 7;
   localparam int HOLD_W = 3;
   localparam int OFS_W  = 16;
   localparam int STEP_W = 6;
   localparam int BYTE_W = 8;
   localparam int TICK_W = 6;
   localparam int GAP_W  = 2;

   localparam logic [SEC_W-1:0]  REPORT_SECOND    = 17'd85800;
   localparam logic [TICK_W-1:0] TICKS_PER_MINUTE = 6'd60;
   localparam logic [TICK_W-1:0] MARK_MINUTE      = 6'd45;
   localparam logic [GAP_W:0]    RX_GAP_LIMIT     = 3'd2;
   localparam logic [BYTE_W-1:0] CHAR_O           = 8'h4F;
   localparam logic [BYTE_W-1:0] CHAR_K           = 8'h4B;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_BYTE = 1'b1;

   localparam logic [1:0] CHG_NONE  = 2'd0;
   localparam logic [1:0] CHG_LOWER = 2'd1;
   localparam logic [1:0] CHG_RAISE = 2'd2;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 17;
   localparam logic [CSR_IDX_W-1:0] CSR_TARIFF_ENABLE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DAY_SWITCH    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NIGHT_SWITCH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TARIFF_STEP   = 3'd3;

   localparam logic [SEC_W-1:0] DAY_SWITCH_RESET   = 17'd25200;
   localparam logic [SEC_W-1:0] NIGHT_SWITCH_RESET = 17'd82800;

   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 64;

   typedef struct packed {
      logic              op;
      logic [BYTE_W-1:0] rx_byte;
      logic              link_up;
      logic              init_busy;
      logic              mains_absent;
      logic              heating_on;
      logic              button_released;
   } item_type;

   typedef struct packed {
      logic              tariff_enable;
      logic [SEC_W-1:0]  day_switch_second;
      logic [SEC_W-1:0]  night_switch_second;
      logic [STEP_W-1:0] tariff_step;
   } cfg_type;

   typedef struct packed {
      logic                    ok_seen;
      logic                    rx_done;
      logic                    reconnect_request;
      logic                    report_due;
      logic                    hourly_mark;
      logic                    reset_request;
      logic [1:0]              setpoint_change;
      logic signed [OFS_W-1:0] setpoint_offset;
      logic [SEC_W-1:0]        seconds_of_day;
      logic [MIN_W-1:0]        mains_off_minutes;
      logic [MIN_W-1:0]        heating_minutes;
   } result_type;

endpackage

// ----- rtl/tssup_core.sv -----
// supervisor state registers and the single-pass update for one event
module tssup_core #(
   parameter int DAY_LAST_SECOND = tssup_pkg::DAY_LAST_SECOND_DEF,
   parameter int DOWN_LIMIT      = tssup_pkg::DOWN_LIMIT_DEF,
   parameter int MINUTE_CAP      = tssup_pkg::MINUTE_CAP_DEF,
   parameter int HOLD_LIMIT      = tssup_pkg::HOLD_LIMIT_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  tssup_pkg::cfg_type     cfg,
   input  logic                   fire,
   input  tssup_pkg::item_type    item,
   output tssup_pkg::result_type  result
);
   import tssup_pkg::*;

   function automatic logic signed [OFS_W-1:0] sat16(input logic signed [OFS_W+1:0] v);
      logic signed [OFS_W-1:0] r;
      if (v > 18'sd32767) begin
         r = 16'sh7FFF;
      end else if (v < -18'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[OFS_W-1:0];
      end
      return r;
   endfunction

   logic [SEC_W-1:0]        day_ff, day_in;
   logic [TICK_W-1:0]       tick_ff, tick_in;
   logic                    mark_ff, mark_in;
   logic [MIN_W-1:0]        off_ff, off_in;
   logic [MIN_W-1:0]        heat_ff, heat_in;
   logic [DOWN_W-1:0]       down_ff, down_in;
   logic                    rx_active_ff, rx_active_in;
   logic [GAP_W-1:0]        gap_ff, gap_in;
   logic                    prev_valid_ff, prev_valid_in;
   logic [BYTE_W-1:0]       prev_byte_ff, prev_byte_in;
   logic [HOLD_W-1:0]       hold_ff, hold_in;
   logic signed [OFS_W-1:0] ofs_ff, ofs_in;

   // tick path arithmetic
   logic [SEC_W:0]          day_inc;
   logic                    day_wrap;
   logic [SEC_W-1:0]        day_next;
   logic [TICK_W-1:0]       tick_inc;
   logic                    minute_full;
   logic [TICK_W-1:0]       tick_next;
   logic [MIN_W-1:0]        off_base, heat_base;
   logic [MIN_W:0]          off_inc, heat_inc;
   logic [MIN_W-1:0]        off_next, heat_next;
   logic [DOWN_W:0]         down_inc;
   logic [GAP_W:0]          gap_inc;
   logic [HOLD_W:0]         hold_inc;
   logic                    day_hit, night_hit;
   logic signed [OFS_W+1:0] ofs_wide, step_wide;
   logic signed [OFS_W-1:0] ofs_lowered, ofs_mid, ofs_raised;
   logic                    ok_pair;

   assign day_inc     = {1'b0, day_ff} + {{SEC_W{1'b0}}, 1'b1};
   assign day_wrap    = day_inc > (SEC_W+1)'(DAY_LAST_SECOND);
   assign day_next    = day_wrap ? '0 : day_inc[SEC_W-1:0];
   assign tick_inc    = tick_ff + 6'd1;
   assign minute_full = tick_inc == TICKS_PER_MINUTE;
   assign tick_next   = minute_full ? '0 : tick_inc;

   // the day wrap clears the totals before a completing minute is added
   assign off_base  = day_wrap ? '0 : off_ff;
   assign heat_base = day_wrap ? '0 : heat_ff;
   assign off_inc   = {1'b0, off_base} + {{MIN_W{1'b0}}, item.mains_absent};
   assign heat_inc  = {1'b0, heat_base} + {{MIN_W{1'b0}}, item.heating_on};
   assign off_next  = !minute_full ? off_base :
                      (off_inc > (MIN_W+1)'(MINUTE_CAP)) ? '0 : off_inc[MIN_W-1:0];
   assign heat_next = !minute_full ? heat_base :
                      (heat_inc > (MIN_W+1)'(MINUTE_CAP)) ? '0 : heat_inc[MIN_W-1:0];

   assign down_inc = {1'b0, down_ff} + {{DOWN_W{1'b0}}, 1'b1};
   assign gap_inc  = {1'b0, gap_ff} + {{GAP_W{1'b0}}, (rx_active_ff & ~item.init_busy)};
   assign hold_inc = {1'b0, hold_ff} + {{HOLD_W{1'b0}}, 1'b1};

   assign day_hit   = cfg.tariff_enable && (day_next == cfg.day_switch_second);
   assign night_hit = cfg.tariff_enable && (day_next == cfg.night_switch_second);
   assign ofs_wide  = {{2{ofs_ff[OFS_W-1]}}, ofs_ff};
   assign step_wide = {{(OFS_W+2-STEP_W){1'b0}}, cfg.tariff_step};
   assign ofs_lowered = sat16(ofs_wide - step_wide);
   assign ofs_mid     = day_hit ? ofs_lowered : ofs_ff;
   assign ofs_raised  = sat16({{2{ofs_mid[OFS_W-1]}}, ofs_mid} + step_wide);

   assign ok_pair = prev_valid_ff && (prev_byte_ff == CHAR_O) && (item.rx_byte == CHAR_K);

   always_comb begin
      day_in        = day_ff;
      tick_in       = tick_ff;
      mark_in       = mark_ff;
      off_in        = off_ff;
      heat_in       = heat_ff;
      down_in       = down_ff;
      rx_active_in  = rx_active_ff;
      gap_in        = gap_ff;
      prev_valid_in = prev_valid_ff;
      prev_byte_in  = prev_byte_ff;
      hold_in       = hold_ff;
      ofs_in        = ofs_ff;
      result        = '0;
      result.setpoint_change = CHG_NONE;

      if (item.op == OP_BYTE) begin
         rx_active_in = 1'b1;
         gap_in       = '0;
         if (ok_pair) begin
            result.ok_seen = 1'b1;
            prev_valid_in  = 1'b0;
            prev_byte_in   = '0;
         end else begin
            prev_valid_in  = 1'b1;
            prev_byte_in   = item.rx_byte;
         end
      end else begin
         if (!item.link_up) begin
            if (down_inc > (DOWN_W+1)'(DOWN_LIMIT)) begin
               down_in = '0;
               result.reconnect_request = 1'b1;
            end else begin
               down_in = down_inc[DOWN_W-1:0];
            end
         end else begin
            down_in = '0;
         end

         if (gap_inc > RX_GAP_LIMIT) begin
            gap_in       = '0;
            rx_active_in = 1'b0;
            result.rx_done = 1'b1;
         end else begin
            gap_in = gap_inc[GAP_W-1:0];
         end

         day_in  = day_next;
         tick_in = tick_next;
         off_in  = off_next;
         heat_in = heat_next;
         result.report_due = day_next == REPORT_SECOND;

         if (tick_next == MARK_MINUTE) begin
            result.hourly_mark = ~mark_ff;
            mark_in = 1'b1;
         end else begin
            mark_in = 1'b0;
         end

         // equal switch seconds: lower then raise, reported as raised
         if (night_hit) begin
            ofs_in = ofs_raised;
            result.setpoint_change = CHG_RAISE;
         end else if (day_hit) begin
            ofs_in = ofs_lowered;
            result.setpoint_change = CHG_LOWER;
         end

         if (item.button_released) begin
            hold_in = '0;
         end else if (hold_inc > (HOLD_W+1)'(HOLD_LIMIT)) begin
            hold_in = '0;
            result.reset_request = 1'b1;
         end else begin
            hold_in = hold_inc[HOLD_W-1:0];
         end
      end

      result.setpoint_offset   = ofs_in;
      result.seconds_of_day    = day_in;
      result.mains_off_minutes = off_in;
      result.heating_minutes   = heat_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         day_ff        <= '0;
         tick_ff       <= '0;
         mark_ff       <= 1'b0;
         off_ff        <= '0;
         heat_ff       <= '0;
         down_ff       <= '0;
         rx_active_ff  <= 1'b0;
         gap_ff        <= '0;
         prev_valid_ff <= 1'b0;
         prev_byte_ff  <= '0;
         hold_ff       <= '0;
         ofs_ff        <= '0;
      end else if (fire) begin
         day_ff        <= day_in;
         tick_ff       <= tick_in;
         mark_ff       <= mark_in;
         off_ff        <= off_in;
         heat_ff       <= heat_in;
         down_ff       <= down_in;
         rx_active_ff  <= rx_active_in;
         gap_ff        <= gap_in;
         prev_valid_ff <= prev_valid_in;
         prev_byte_ff  <= prev_byte_in;
         hold_ff       <= hold_in;
         ofs_ff        <= ofs_in;
      end
   end

endmodule

// ----- rtl/thermostat_second_tick_supervisor.sv -----
// top level of the thermostat second tick supervisor: stream ports, config registers, staging
// One event (a one-second tick, or a received serial byte when req_tuser is 1) enters per
// clock while req_tready is high and yields exactly one result beat: the event is held in the
// input register, then the whole update runs in one combinational pass into the result
// register. Events may follow back to back; the input stays ready while a result waits, and
// only stalls when both the input and result registers are full and rsp_tready is low.
// The user writes tariff registers via the csr port only while the block is idle; the block
// does not enforce it. csr_ready is always high and writes to unknown indexes are dropped.
module thermostat_second_tick_supervisor #(
   parameter int DAY_LAST_SECOND = tssup_pkg::DAY_LAST_SECOND_DEF,
   parameter int DOWN_LIMIT      = tssup_pkg::DOWN_LIMIT_DEF,
   parameter int MINUTE_CAP      = tssup_pkg::MINUTE_CAP_DEF,
   parameter int HOLD_LIMIT      = tssup_pkg::HOLD_LIMIT_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // rx_byte[7:0], link_up, init_busy, mains_absent, heating_on, button_released, zero pad
   input  logic [tssup_pkg::REQ_TDATA_W-1:0] req_tdata,
   // op
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // ok_seen, rx_done, reconnect_request, report_due, hourly_mark, reset_request,
   // setpoint_change[1:0], setpoint_offset[15:0], seconds_of_day[16:0],
   // mains_off_minutes[10:0], heating_minutes[10:0], zero pad
   output logic [tssup_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [tssup_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tssup_pkg::CSR_DATA_W-1:0] csr_data
);
   import tssup_pkg::*;

   logic       in_valid_ff, in_valid_in;
   item_type   in_item_ff;
   item_type   req_item;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_result_ff;
   result_type core_result;
   cfg_type    cfg_ff;
   logic       req_fire, advance, csr_fire;

   assign req_item.op              = req_tuser;
   assign req_item.rx_byte         = req_tdata[7:0];
   assign req_item.link_up         = req_tdata[8];
   assign req_item.init_busy       = req_tdata[9];
   assign req_item.mains_absent    = req_tdata[10];
   assign req_item.heating_on      = req_tdata[11];
   assign req_item.button_released = req_tdata[12];

   assign advance     = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || advance;
   assign req_fire    = req_tvalid && req_tready;
   assign in_valid_in = req_fire || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);
   assign csr_ready   = 1'b1;
   assign csr_fire    = csr_valid && csr_ready;

   tssup_core #(
      .DAY_LAST_SECOND (DAY_LAST_SECOND),
      .DOWN_LIMIT      (DOWN_LIMIT),
      .MINUTE_CAP      (MINUTE_CAP),
      .HOLD_LIMIT      (HOLD_LIMIT)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .fire   (advance),
      .item   (in_item_ff),
      .result (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff <= req_item;
      end
      if (advance) begin
         rsp_result_ff <= core_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tariff_enable       <= 1'b0;
         cfg_ff.day_switch_second   <= DAY_SWITCH_RESET;
         cfg_ff.night_switch_second <= NIGHT_SWITCH_RESET;
         cfg_ff.tariff_step         <= '0;
      end else if (csr_fire) begin
         case (csr_index)
            CSR_TARIFF_ENABLE: begin
               cfg_ff.tariff_enable <= csr_data[0];
            end
            CSR_DAY_SWITCH: begin
               cfg_ff.day_switch_second <= csr_data[SEC_W-1:0];
            end
            CSR_NIGHT_SWITCH: begin
               cfg_ff.night_switch_second <= csr_data[SEC_W-1:0];
            end
            CSR_TARIFF_STEP: begin
               cfg_ff.tariff_step <= csr_data[STEP_W-1:0];
            end
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0,
                        rsp_result_ff.heating_minutes,
                        rsp_result_ff.mains_off_minutes,
                        rsp_result_ff.seconds_of_day,
                        rsp_result_ff.setpoint_offset,
                        rsp_result_ff.setpoint_change,
                        rsp_result_ff.reset_request,
                        rsp_result_ff.hourly_mark,
                        rsp_result_ff.report_due,
                        rsp_result_ff.reconnect_request,
                        rsp_result_ff.rx_done,
                        rsp_result_ff.ok_seen};

   // a byte beat never raises tick pulses or a setpoint change
   assert property (@(posedge clock) disable iff (reset)
      advance && in_item_ff.op == OP_BYTE |=>
         rsp_result_ff.rx_done == 1'b0 && rsp_result_ff.reconnect_request == 1'b0 &&
         rsp_result_ff.report_due == 1'b0 && rsp_result_ff.hourly_mark == 1'b0 &&
         rsp_result_ff.reset_request == 1'b0 && rsp_result_ff.setpoint_change == CHG_NONE)
      else $error("byte beat produced tick outputs");

   // a draining output never blocks the input side
   assert property (@(posedge clock) disable iff (reset) rsp_tready |-> req_tready)
      else $error("input stalled while output drains");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_result_ff.seconds_of_day <= SEC_W'(DAY_LAST_SECOND))
      else $error("time of day past end of day");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_result_ff.mains_off_minutes <= MIN_W'(MINUTE_CAP) &&
                       rsp_result_ff.heating_minutes <= MIN_W'(MINUTE_CAP))
      else $error("minute total past cap");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_result_ff.setpoint_change != 2'd3)
      else $error("invalid setpoint change code");

endmodule
